/* rtl/triangle_tangent_space_assert.svh */
// Assertion macros shared by the triangle tangent space RTL.
`ifndef TRIANGLE_TANGENT_SPACE_ASSERT_SVH
`define TRIANGLE_TANGENT_SPACE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TTS_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");
`define TTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define TTS_ASSERT_NEVER(lbl, clk, rst, cond)
`define TTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/tts_pkg.sv */
// Types and constants of the triangle tangent space block.
`default_nettype none
package tts_pkg;
   localparam int IDX_W    = 24;
   localparam int DATA_W   = 32;
   localparam int DELTA_W  = 33;
   localparam int PROD_W   = 66;
   localparam int NUM_W    = 67;
   localparam int REM_W    = 68;
   localparam int QUO_W    = 32;
   localparam int QDEPTH   = 2;
   localparam int NUM_CNT  = 7;
   localparam int RES_CNT  = 6;
   localparam int PROD_CNT = 14;

   typedef struct packed {
      logic [IDX_W-1:0]         vertex_index;
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
      logic signed [DATA_W-1:0] tex_u;
      logic signed [DATA_W-1:0] tex_v;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         out_index;
      logic signed [DATA_W-1:0] tangent_x;
      logic signed [DATA_W-1:0] tangent_y;
      logic signed [DATA_W-1:0] tangent_z;
      logic signed [DATA_W-1:0] bitangent_x;
      logic signed [DATA_W-1:0] bitangent_y;
      logic signed [DATA_W-1:0] bitangent_z;
      logic                     degenerate;
      logic                     last_of_triangle;
   } rsp_type;

   // one triangle, as handed from front to back
   typedef struct packed {
      logic [IDX_W-1:0]              idx0;
      logic [IDX_W-1:0]              idx1;
      logic [IDX_W-1:0]              idx2;
      logic [2:0][DELTA_W-1:0]       dp1;
      logic [2:0][DELTA_W-1:0]       dp2;
      logic [DELTA_W-1:0]            du1;
      logic [DELTA_W-1:0]            dv1;
      logic [DELTA_W-1:0]            du2;
      logic [DELTA_W-1:0]            dv2;
   } job_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_THIRD
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_OUT
   } back_state_type;
endpackage
`default_nettype wire

/* rtl/tts_front.sv */
// Vertex intake: holds the first two vertices and forms the triangle deltas.
`default_nettype none
module tts_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tts_pkg::req_type req_data,
   input  wire logic             q_full,
   output logic                  push,
   output tts_pkg::job_type      push_data
);
   tts_pkg::phase_type                 phase_ff, phase_in;
   logic [tts_pkg::IDX_W-1:0]          idx0_ff, idx1_ff;
   logic [2:0][tts_pkg::DATA_W-1:0]    pos0_ff, pos1_ff;
   logic [tts_pkg::DATA_W-1:0]         u0_ff, v0_ff, u1_ff, v1_ff;
   logic [2:0][tts_pkg::DATA_W-1:0]    pos_in;
   logic                               accept, load0, load1;

   assign pos_in = {req_data.pos_z, req_data.pos_y, req_data.pos_x};

   // outputs of the phase machine
   always_comb begin
      req_ready = (phase_ff == tts_pkg::PH_THIRD) ? !q_full : 1'b1;
      accept    = req_valid && req_ready;
      push      = accept && (phase_ff == tts_pkg::PH_THIRD);
      load1     = accept && (phase_ff == tts_pkg::PH_SECOND);
      load0     = accept && (phase_ff != tts_pkg::PH_SECOND) &&
                  (phase_ff != tts_pkg::PH_THIRD);
   end

   // next phase; an unused code behaves as the first vertex
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            tts_pkg::PH_SECOND: phase_in = tts_pkg::PH_THIRD;
            tts_pkg::PH_THIRD:  phase_in = tts_pkg::PH_FIRST;
            default:            phase_in = tts_pkg::PH_SECOND;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tts_pkg::PH_FIRST;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // held vertices
   always_ff @(posedge clock) begin
      if (load0) begin
         idx0_ff <= req_data.vertex_index;
         pos0_ff <= pos_in;
         u0_ff   <= req_data.tex_u;
         v0_ff   <= req_data.tex_v;
      end
      if (load1) begin
         idx1_ff <= req_data.vertex_index;
         pos1_ff <= pos_in;
         u1_ff   <= req_data.tex_u;
         v1_ff   <= req_data.tex_v;
      end
   end

   // exact 33-bit deltas against vertex 0
   always_comb begin
      push_data.idx0 = idx0_ff;
      push_data.idx1 = idx1_ff;
      push_data.idx2 = req_data.vertex_index;
      for (int a = 0; a < 3; a++) begin
         push_data.dp1[a] = {pos1_ff[a][31], pos1_ff[a]} - {pos0_ff[a][31], pos0_ff[a]};
         push_data.dp2[a] = {pos_in[a][31], pos_in[a]} - {pos0_ff[a][31], pos0_ff[a]};
      end
      push_data.du1 = {u1_ff[31], u1_ff} - {u0_ff[31], u0_ff};
      push_data.dv1 = {v1_ff[31], v1_ff} - {v0_ff[31], v0_ff};
      push_data.du2 = {req_data.tex_u[31], req_data.tex_u} - {u0_ff[31], u0_ff};
      push_data.dv2 = {req_data.tex_v[31], req_data.tex_v} - {v0_ff[31], v0_ff};
   end
endmodule
`default_nettype wire

/* rtl/tts_queue.sv */
// Two-entry triangle queue between intake and compute.
`default_nettype none
`include "triangle_tangent_space_assert.svh"
module tts_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire tts_pkg::job_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output tts_pkg::job_type      pop_data,
   output logic                  not_empty
);
   tts_pkg::job_type mem_ff [tts_pkg::QDEPTH];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'(tts_pkg::QDEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TTS_ASSERT_NEVER(a_push_full, clock, reset, push && full)
   `TTS_ASSERT_NEVER(a_pop_empty, clock, reset, pop && !not_empty)
   `TTS_ASSERT_NEVER(a_count_range, clock, reset, count_ff > 2'(tts_pkg::QDEPTH))
endmodule
`default_nettype wire

/* rtl/tts_back.sv */
// Compute engine: shared multiplier, bit-serial divider and result beats.
`default_nettype none
`include "triangle_tangent_space_assert.svh"
module tts_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire tts_pkg::job_type job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tts_pkg::rsp_type      rsp_data
);
   tts_pkg::back_state_type              state_ff, state_in;
   logic [5:0]                           step_ff, step_in;
   logic [2:0]                           comp_ff, comp_in;
   logic [1:0]                           beat_ff, beat_in;
   logic [3:0]                           psel_ff;
   logic signed [tts_pkg::PROD_W-1:0]    prod_ff;
   logic signed [tts_pkg::NUM_W-1:0]     num_ff [tts_pkg::NUM_CNT];
   logic [tts_pkg::NUM_W-1:0]            md_ff;
   logic                                 det_neg_ff, degen_ff, sat_ff, neg_ff;
   logic [tts_pkg::REM_W-1:0]            rem_ff;
   logic [tts_pkg::QUO_W-1:0]            dvd_ff, quo_ff;
   logic [tts_pkg::DATA_W-1:0]           res_ff [tts_pkg::RES_CNT];
   logic                                 rsp_valid_ff, rsp_valid_in;
   tts_pkg::rsp_type                     rsp_ff;

   logic signed [tts_pkg::DELTA_W-1:0]   op_a, op_b;
   logic [3:0]                           pm_op, pm_acc;
   logic [2:0]                           tgt;
   logic signed [tts_pkg::NUM_W-1:0]     num_sel;
   logic [tts_pkg::NUM_W-1:0]            mag;
   logic [tts_pkg::REM_W-1:0]            r_shift;
   logic                                 r_ge, load_beat;
   logic [tts_pkg::QUO_W-1:0]            limit, quo_m;
   logic [tts_pkg::NUM_W-1:0]            det_abs;

   // pick one of three position deltas
   function automatic logic [tts_pkg::DELTA_W-1:0] pick(
      input logic [2:0][tts_pkg::DELTA_W-1:0] v, input logic [1:0] a);
      logic [tts_pkg::DELTA_W-1:0] r;
      case (a)
         2'd0:    r = v[0];
         2'd1:    r = v[1];
         default: r = v[2];
      endcase
      return r;
   endfunction

   // product schedule: det terms first, then tangent and bitangent terms per axis
   always_comb begin
      pm_op = step_ff[3:0] - 4'd2;
      op_a  = job.du1;
      op_b  = job.dv2;
      if (step_ff[3:0] == 4'd1) begin
         op_a = job.dv1;
         op_b = job.du2;
      end else if (step_ff[3:0] >= 4'd2) begin
         case (pm_op[1:0])
            2'd0:    begin op_a = pick(job.dp1, pm_op[3:2]); op_b = job.dv2; end
            2'd1:    begin op_a = pick(job.dp2, pm_op[3:2]); op_b = job.dv1; end
            2'd2:    begin op_a = pick(job.dp2, pm_op[3:2]); op_b = job.du1; end
            default: begin op_a = pick(job.dp1, pm_op[3:2]); op_b = job.du2; end
         endcase
      end
      pm_acc = psel_ff - 4'd2;
      if (psel_ff < 4'd2) begin
         tgt = 3'd0;
      end else if (pm_acc[1]) begin
         tgt = 3'd4 + 3'(pm_acc[3:2]);
      end else begin
         tgt = 3'd1 + 3'(pm_acc[3:2]);
      end
   end

   // divider datapath
   always_comb begin
      num_sel = num_ff[comp_ff + 3'd1];
      mag     = num_sel[tts_pkg::NUM_W-1] ? -num_sel : num_sel;
      r_shift = {rem_ff[tts_pkg::REM_W-2:0], dvd_ff[tts_pkg::QUO_W-1]};
      r_ge    = r_shift >= {1'b0, md_ff};
      limit   = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      quo_m   = (sat_ff || quo_ff > limit) ? limit : quo_ff;
      det_abs = num_ff[0][tts_pkg::NUM_W-1] ? -num_ff[0] : num_ff[0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      comp_in  = comp_ff;
      beat_in  = beat_ff;
      case (state_ff)
         tts_pkg::BK_IDLE: begin
            step_in = 6'd0;
            if (job_valid) state_in = tts_pkg::BK_MUL;
         end
         tts_pkg::BK_MUL: begin
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(tts_pkg::PROD_CNT)) begin
               step_in  = 6'd0;
               comp_in  = 3'd0;
               beat_in  = 2'd0;
               state_in = (num_ff[0] == '0) ? tts_pkg::BK_OUT : tts_pkg::BK_DIV;
            end
         end
         tts_pkg::BK_DIV: begin
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd33) begin
               step_in = 6'd0;
               comp_in = comp_ff + 3'd1;
               if (comp_ff == 3'(tts_pkg::RES_CNT - 1)) state_in = tts_pkg::BK_OUT;
            end
         end
         tts_pkg::BK_OUT: begin
            if (load_beat) begin
               beat_in = beat_ff + 2'd1;
               if (beat_ff == 2'd2) begin
                  beat_in  = 2'd0;
                  state_in = tts_pkg::BK_IDLE;
               end
            end
         end
         default: state_in = tts_pkg::BK_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      load_beat    = (state_ff == tts_pkg::BK_OUT) && (!rsp_valid_ff || rsp_ready);
      pop          = load_beat && (beat_ff == 2'd2);
      rsp_valid_in = load_beat ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tts_pkg::BK_IDLE;
         step_ff      <= 6'd0;
         comp_ff      <= 3'd0;
         beat_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         comp_ff      <= comp_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // multiply and accumulate
   always_ff @(posedge clock) begin
      if (state_ff == tts_pkg::BK_IDLE) begin
         for (int i = 0; i < tts_pkg::NUM_CNT; i++) num_ff[i] <= '0;
      end
      if (state_ff == tts_pkg::BK_MUL) begin
         if (step_ff < 6'(tts_pkg::PROD_CNT)) begin
            prod_ff <= op_a * op_b;
            psel_ff <= step_ff[3:0];
         end
         if (step_ff != 6'd0) begin
            if (psel_ff[0]) num_ff[tgt] <= num_ff[tgt] - {prod_ff[tts_pkg::PROD_W-1], prod_ff};
            else            num_ff[tgt] <= num_ff[tgt] + {prod_ff[tts_pkg::PROD_W-1], prod_ff};
         end
         if (step_ff == 6'(tts_pkg::PROD_CNT)) begin
            md_ff      <= det_abs;
            det_neg_ff <= num_ff[0][tts_pkg::NUM_W-1];
            degen_ff   <= (num_ff[0] == '0);
         end
      end
   end

   // restoring division, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (state_ff == tts_pkg::BK_DIV) begin
         if (step_ff == 6'd0) begin
            rem_ff <= {17'd0, mag[tts_pkg::NUM_W-1:16]};
            dvd_ff <= {mag[15:0], 16'd0};
            sat_ff <= {16'd0, mag[tts_pkg::NUM_W-1:16]} >= md_ff;
            neg_ff <= num_sel[tts_pkg::NUM_W-1] ^ det_neg_ff;
            quo_ff <= '0;
         end else if (step_ff == 6'd33) begin
            res_ff[comp_ff] <= neg_ff ? -quo_m : quo_m;
         end else begin
            rem_ff <= r_ge ? r_shift - {1'b0, md_ff} : r_shift;
            dvd_ff <= dvd_ff << 1;
            quo_ff <= {quo_ff[tts_pkg::QUO_W-2:0], r_ge};
         end
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (load_beat) begin
         case (beat_ff)
            2'd0:    rsp_ff.out_index <= job.idx0;
            2'd1:    rsp_ff.out_index <= job.idx1;
            default: rsp_ff.out_index <= job.idx2;
         endcase
         rsp_ff.tangent_x        <= degen_ff ? '0 : res_ff[0];
         rsp_ff.tangent_y        <= degen_ff ? '0 : res_ff[1];
         rsp_ff.tangent_z        <= degen_ff ? '0 : res_ff[2];
         rsp_ff.bitangent_x      <= degen_ff ? '0 : res_ff[3];
         rsp_ff.bitangent_y      <= degen_ff ? '0 : res_ff[4];
         rsp_ff.bitangent_z      <= degen_ff ? '0 : res_ff[5];
         rsp_ff.degenerate       <= degen_ff;
         rsp_ff.last_of_triangle <= (beat_ff == 2'd2);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TTS_ASSERT_IMPLY(a_degen_zero, clock, reset, rsp_valid_ff && rsp_ff.degenerate,
      rsp_ff.tangent_x == '0 && rsp_ff.bitangent_z == '0)
   `TTS_ASSERT_IMPLY(a_idle_beat, clock, reset, state_ff == tts_pkg::BK_IDLE, beat_ff == 2'd0)
   `TTS_ASSERT_IMPLY(a_div_nondegen, clock, reset, state_ff == tts_pkg::BK_DIV, !degen_ff)
endmodule
`default_nettype wire

/* rtl/triangle_tangent_space.sv */
// Top level: vertices in, per-vertex tangent and bitangent beats out.
// Vertices are taken one per cycle; the third vertex of each triangle waits while the two-entry triangle queue is full.
// Per triangle the engine passes through its idle state, forms 14 shared 33x33 products,
// runs each of the six components through a one-bit-per-cycle divider (skipped on a zero
// determinant), then sends 3 output beats. Synchronous reset clears control.
`default_nettype none
module triangle_tangent_space (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tts_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tts_pkg::rsp_type      rsp_data
);
   logic             push, full, pop, not_empty;
   tts_pkg::job_type push_data, pop_data;

   tts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (full),
      .push      (push),
      .push_data (push_data)
   );

   tts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty)
   );

   tts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (not_empty),
      .job       (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

/* test/tb_top.sv */
// Tests triangle_tangent_space: directed and random vertices, scoreboard prediction, idle phases.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

   // tangent frame predictor and queue of expected vertex results
   class tangent_scoreboard;
      logic [tts_pkg::IDX_W-1:0] held_idx [2];
      logic signed [tts_pkg::DATA_W-1:0] held_pos [6];
      logic signed [tts_pkg::DATA_W-1:0] held_uv [4];
      int unsigned phase;
      tts_pkg::rsp_type pending_results [$];
      int errors;

      function void clear();
         phase = 0;
         errors = 0;
         foreach (held_idx[i]) held_idx[i] = '0;
         foreach (held_pos[i]) held_pos[i] = '0;
         foreach (held_uv[i]) held_uv[i] = '0;
      endfunction

      // (num * 2^16) / det truncated toward zero, saturated to 32 bits
      function logic signed [tts_pkg::DATA_W-1:0] scaled_quotient(logic signed [79:0] num,
                                                                  logic signed [79:0] det);
         logic signed [99:0] q;
         q = (100'(num) <<< 16) / 100'(det);
         if (q > 100'sh7FFFFFFF) return 32'sh7FFFFFFF;
         if (q < -100'sh80000000) return 32'sh80000000;
         return q[31:0];
      endfunction

      function void vertex_accepted(tts_pkg::req_type v);
         logic signed [79:0] dp1 [3];
         logic signed [79:0] dp2 [3];
         logic signed [79:0] du1, dv1, du2, dv2, det;
         logic signed [tts_pkg::DATA_W-1:0] tan [3];
         logic signed [tts_pkg::DATA_W-1:0] bit_v [3];
         logic signed [tts_pkg::DATA_W-1:0] cur [3];
         logic [tts_pkg::IDX_W-1:0] idx [3];
         tts_pkg::rsp_type r;
         cur[0] = v.pos_x; cur[1] = v.pos_y; cur[2] = v.pos_z;
         if (phase < 2) begin
            held_idx[phase] = v.vertex_index;
            for (int a = 0; a < 3; a++) held_pos[phase*3+a] = cur[a];
            held_uv[phase*2] = v.tex_u;
            held_uv[phase*2+1] = v.tex_v;
            phase++;
            return;
         end
         for (int a = 0; a < 3; a++) begin
            dp1[a] = 80'(held_pos[3+a]) - 80'(held_pos[a]);
            dp2[a] = 80'(cur[a]) - 80'(held_pos[a]);
         end
         du1 = 80'(held_uv[2]) - 80'(held_uv[0]);
         dv1 = 80'(held_uv[3]) - 80'(held_uv[1]);
         du2 = 80'(v.tex_u) - 80'(held_uv[0]);
         dv2 = 80'(v.tex_v) - 80'(held_uv[1]);
         det = du1 * dv2 - dv1 * du2;
         for (int a = 0; a < 3; a++) begin
            if (det == 0) begin
               tan[a] = '0;
               bit_v[a] = '0;
            end else begin
               tan[a] = scaled_quotient(dp1[a] * dv2 - dp2[a] * dv1, det);
               bit_v[a] = scaled_quotient(dp2[a] * du1 - dp1[a] * du2, det);
            end
         end
         idx[0] = held_idx[0]; idx[1] = held_idx[1]; idx[2] = v.vertex_index;
         for (int k = 0; k < 3; k++) begin
            r.out_index = idx[k];
            r.tangent_x = tan[0]; r.tangent_y = tan[1]; r.tangent_z = tan[2];
            r.bitangent_x = bit_v[0]; r.bitangent_y = bit_v[1]; r.bitangent_z = bit_v[2];
            r.degenerate = (det == 0);
            r.last_of_triangle = (k == 2);
            pending_results.push_back(r);
         end
         phase = 0;
      endfunction

      task result_seen(tts_pkg::rsp_type got);
         tts_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat", '0, got);
            return;
         end
         want = pending_results.pop_front();
         if (got.out_index !== want.out_index) report_mismatch("out_index", want, got);
         if (got.tangent_x !== want.tangent_x) report_mismatch("tangent_x", want, got);
         if (got.tangent_y !== want.tangent_y) report_mismatch("tangent_y", want, got);
         if (got.tangent_z !== want.tangent_z) report_mismatch("tangent_z", want, got);
         if (got.bitangent_x !== want.bitangent_x) report_mismatch("bitangent_x", want, got);
         if (got.bitangent_y !== want.bitangent_y) report_mismatch("bitangent_y", want, got);
         if (got.bitangent_z !== want.bitangent_z) report_mismatch("bitangent_z", want, got);
         if (got.degenerate !== want.degenerate) report_mismatch("degenerate", want, got);
         if (got.last_of_triangle !== want.last_of_triangle)
            report_mismatch("last_of_triangle", want, got);
      endtask

      task report_mismatch(string what, tts_pkg::rsp_type want, tts_pkg::rsp_type got);
         errors++;
         $display("mismatch %s: want %h got %h", what, want, got);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tts_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tts_pkg::rsp_type rsp_data;

   tangent_scoreboard board;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit stim_done = 1'b0;

   triangle_tangent_space uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit: ~160 triangles, with heavy stalls, many times over
   initial begin
      #20ms;
      $display("triangle_tangent_space test failed");
      $finish;
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.vertex_accepted(req_data);
         if (rsp_valid && rsp_ready) board.result_seen(rsp_data);
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   function logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(15) << 16;
         3: return 32'($signed($urandom_range(8)) - 4) <<< 16;
         default: return $urandom;
      endcase
   endfunction

   // one vertex beat; valid held until accepted, dropped only while idling
   task automatic send_vertex(tts_pkg::req_type v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= v;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_vertex();
      tts_pkg::req_type v;
      logic [31:0] rnd;
      rnd = $urandom;
      v.vertex_index = rnd[tts_pkg::IDX_W-1:0];
      v.pos_x = rand_coord(); v.pos_y = rand_coord(); v.pos_z = rand_coord();
      v.tex_u = rand_coord(); v.tex_v = rand_coord();
      send_vertex(v);
   endtask

   task automatic send_triangle(logic [31:0] u0, v0, u1, v1, u2, v2, logic [31:0] p);
      tts_pkg::req_type v;
      logic [31:0] us [3];
      logic [31:0] vs [3];
      logic [31:0] rnd;
      us[0] = u0; us[1] = u1; us[2] = u2;
      vs[0] = v0; vs[1] = v1; vs[2] = v2;
      for (int k = 0; k < 3; k++) begin
         rnd = $urandom;
         v.vertex_index = rnd[tts_pkg::IDX_W-1:0];
         v.pos_x = p ^ $urandom_range(1) << 31;
         v.pos_y = ~p;
         v.pos_z = $urandom;
         v.tex_u = us[k]; v.tex_v = vs[k];
         send_vertex(v);
      end
   endtask

   initial begin
      board = new();
      board.clear();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: index extremes, degenerate UV, extreme coordinates, saturation
      begin
         tts_pkg::req_type v;
         v = '{vertex_index: '0, pos_x: 32'h80000000, pos_y: 32'h7FFFFFFF,
               pos_z: '0, tex_u: '0, tex_v: '0};
         send_vertex(v);
         v = '{vertex_index: '1, pos_x: 32'h7FFFFFFF, pos_y: 32'h80000000,
               pos_z: 32'h7FFFFFFF, tex_u: 32'h10000, tex_v: '0};
         send_vertex(v);
         v = '{vertex_index: 24'h555555, pos_x: 32'h80000000, pos_y: '0,
               pos_z: 32'h80000000, tex_u: '0, tex_v: 32'h10000};
         send_vertex(v);
      end
      send_triangle(0, 0, 0, 0, 0, 0, 32'h12345678);
      send_triangle(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 32'h7FFFFFFF);
      send_triangle(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      send_triangle(0, 0, 1, 0, 0, 1, 32'h7FFFFFFF);
      send_triangle(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00010000);
      send_triangle(0, 0, 32'h8000, 0, 0, 32'h8000, 32'hFFFF0000);

      // random phases: none, sender idle, receiver stall, both light
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 57; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 57; end
            default: begin send_idle_pct = 7; stall_pct = 7; end
         endcase
         for (int t = 0; t < 37; t++) begin
            if ($urandom_range(3) == 0)
               send_triangle($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, rand_coord());
            else
               for (int k = 0; k < 3; k++) send_random_vertex();
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // drain then judge
   initial begin
      wait (stim_done);
      while (board.pending_results.size() != 0 || board.phase != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0 && board.pending_results.size() == 0)
         $display("triangle_tangent_space test passed");
      else
         $display("triangle_tangent_space test failed");
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_front.sv
rtl/tts_queue.sv
rtl/tts_back.sv
rtl/triangle_tangent_space.sv
test/tb_top.sv
